// File: sv/stop_pkg.sv
// shared types and constants of the scan to obstacle point converter
`default_nettype none

package stop_pkg;

    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int COORD_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    // cordic datapath: mm with 16 fraction bits, phase in units of 2^-32 turn
    localparam int NUM_ITER = 20;
    localparam int XY_W     = 36;
    localparam int Z_W      = 32;
    localparam int GAIN_W   = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam int GAIN_SHIFT = 14;
    localparam int PROD_W   = RANGE_W + GAIN_W;

    // mm.16 to cm: add half a cm, drop the fraction, divide by ten
    localparam int CM_FRAC  = 16;
    localparam logic [XY_W:0] HALF_CM = (XY_W + 1)'(327680);
    localparam int N_W      = XY_W + 1 - CM_FRAC;
    localparam int RECIP_W  = 19;
    localparam logic [RECIP_W-1:0] RECIP_10 = 19'd419431;
    localparam int RECIP_SHIFT = 22;
    localparam int Q_W      = N_W + RECIP_W - RECIP_SHIFT;
    localparam int SUM_W    = Q_W + 2;

    localparam logic signed [Z_W-1:0] ATAN_TURN [NUM_ITER] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
        32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
        32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
        32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANGE_MIN   = 3'd0,
        REG_RANGE_MAX   = 3'd1,
        REG_START_ANGLE = 3'd2,
        REG_ANGLE_STEP  = 3'd3,
        REG_HEADING     = 3'd4,
        REG_ROBOT_X     = 3'd5,
        REG_ROBOT_Y     = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic  valid;
        quad_t quad;
    } cordic_ctl_t;

endpackage

`default_nettype wire

// File: sv/stop_if.sv
// handshake channels for range samples and obstacle points
`default_nettype none

interface stop_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic [15:0] sample_index;

    modport source (output valid, output range_mm, output sample_index, input ready);
    modport sink   (input valid, input range_mm, input sample_index, output ready);
endinterface

interface stop_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x_cm;
    logic signed [15:0] point_y_cm;

    modport source (output valid, output point_x_cm, output point_y_cm, input ready);
    modport sink   (input valid, input point_x_cm, input point_y_cm, output ready);
endinterface

`default_nettype wire

// File: sv/stop_cordic.sv
// pipelined cordic rotator, one iteration per register stage
`default_nettype none

module stop_cordic
    import stop_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  cordic_ctl_t            in_ctl,
    input  logic signed [XY_W-1:0] in_x,
    input  logic signed [Z_W-1:0]  in_z,
    output cordic_ctl_t            out_ctl,
    output logic signed [XY_W-1:0] out_x,
    output logic signed [XY_W-1:0] out_y
);

    cordic_ctl_t            ctl_reg [NUM_ITER];
    logic signed [XY_W-1:0] x_reg   [NUM_ITER];
    logic signed [XY_W-1:0] y_reg   [NUM_ITER];
    logic signed [Z_W-1:0]  z_reg   [NUM_ITER-1];

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        cordic_ctl_t            ctl_in;
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;

        if (i == 0)
        begin : g_first
            assign ctl_in = in_ctl;
            assign x_in   = in_x;
            assign y_in   = '0;
            assign z_in   = in_z;
        end
        else
        begin : g_next
            assign ctl_in = ctl_reg[i-1];
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_in >= 0)
                begin
                    x_reg[i] <= x_in - (y_in >>> i);
                    y_reg[i] <= y_in + (x_in >>> i);
                end
                else
                begin
                    x_reg[i] <= x_in + (y_in >>> i);
                    y_reg[i] <= y_in - (x_in >>> i);
                end
            end
        end

        // the last iteration needs no residual angle
        if (i < NUM_ITER - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_in >= 0)
                    begin
                        z_reg[i] <= z_in - ATAN_TURN[i];
                    end
                    else
                    begin
                        z_reg[i] <= z_in + ATAN_TURN[i];
                    end
                end
            end
        end
    end

    assign out_ctl = ctl_reg[NUM_ITER-1];
    assign out_x   = x_reg[NUM_ITER-1];
    assign out_y   = y_reg[NUM_ITER-1];

endmodule

`default_nettype wire

// File: sv/scan_to_obstacle_points.sv
// top level: laser range sample to obstacle point in world coordinates
//
//   channel   dir  words                         handshake
//   samples   in   range_mm, sample_index        valid / ready
//   points    out  point_x_cm, point_y_cm        valid / ready
//   cfg       in   cfg_index, cfg_data           cfg_write_en, no back-pressure
//
// one word per cycle sustained while the output register is not stalled
// each sample passes the twenty-stage cordic plus input, quadrant, rounding, divide
// and output stages; out-of-window samples travel as bubbles and give no point
// reset clears the valid bits and loads the register defaults
// a stalled output register freezes the whole pipeline and drops samples.ready
`default_nettype none

module scan_to_obstacle_points
    import stop_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int RANGE_CLAMP_MM = 2000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    stop_in_if.sink                samples,
    stop_out_if.source             points,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PHASE_BITS = (ANGLE_BITS < ANGLE_W) ? ANGLE_BITS : ANGLE_W;
    localparam logic [ANGLE_W-1:0] PHASE_MASK =
        ANGLE_W'(((64'd1 << PHASE_BITS) - 64'd1) << (ANGLE_W - PHASE_BITS));
    localparam logic [RANGE_W-1:0] CLAMP_MM = RANGE_W'(RANGE_CLAMP_MM);

    // configuration registers
    logic [RANGE_W-1:0] lo_mm_reg;
    logic [RANGE_W-1:0] hi_mm_reg;
    logic [ANGLE_W-1:0] start_angle_reg;
    logic [ANGLE_W-1:0] angle_step_reg;
    logic [ANGLE_W-1:0] heading_reg;
    logic [COORD_W-1:0] robot_x_reg;
    logic [COORD_W-1:0] robot_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_mm_reg       <= '0;
            hi_mm_reg       <= RANGE_W'(2000);
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            heading_reg     <= '0;
            robot_x_reg     <= '0;
            robot_y_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RANGE_MIN:   lo_mm_reg       <= cfg_data;
                REG_RANGE_MAX:   hi_mm_reg       <= cfg_data;
                REG_START_ANGLE: start_angle_reg <= cfg_data;
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                REG_HEADING:     heading_reg     <= cfg_data;
                REG_ROBOT_X:     robot_x_reg     <= cfg_data;
                REG_ROBOT_Y:     robot_y_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // pipeline advances unless a finished point is waiting
    logic out_valid_reg;
    logic adv;

    assign adv = !out_valid_reg || points.ready;
    assign samples.ready = adv;

    // stage 0: window check, beam angle, gain-scaled range
    logic [RANGE_W-1:0]     range_hi;
    logic                   in_window;
    logic [2*ANGLE_W-1:0]   step_prod;
    logic [ANGLE_W-1:0]     beam_angle;
    logic [PROD_W-1:0]      gain_prod;
    logic                   s0_valid_reg;
    logic [ANGLE_W-1:0]     s0_angle_reg;
    logic signed [XY_W-1:0] s0_x_reg;

    assign range_hi  = (hi_mm_reg > CLAMP_MM) ? CLAMP_MM : hi_mm_reg;
    assign in_window = (samples.range_mm >= lo_mm_reg) && (samples.range_mm <= range_hi);
    assign step_prod = angle_step_reg * samples.sample_index;
    assign beam_angle = heading_reg + start_angle_reg + step_prod[ANGLE_W-1:0];
    assign gain_prod = PROD_W'(samples.range_mm) * PROD_W'(GAIN_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= samples.valid && in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_angle_reg <= beam_angle & PHASE_MASK;
            s0_x_reg     <= XY_W'(gain_prod >> GAIN_SHIFT);
        end
    end

    // stage 1: nearest quarter turn off, signed residue left
    logic [ANGLE_W-1:0]     angle_round;
    quad_t                  quad;
    logic [Z_W-1:0]         residue;
    cordic_ctl_t            s1_ctl_reg;
    logic signed [XY_W-1:0] s1_x_reg;
    logic signed [Z_W-1:0]  s1_z_reg;

    assign angle_round = s0_angle_reg + ANGLE_W'(16'h2000);
    assign quad        = quad_t'(angle_round[ANGLE_W-1:ANGLE_W-2]);
    assign residue     = {s0_angle_reg, 16'h0000} - {quad, 30'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg.valid <= s0_valid_reg;
            s1_ctl_reg.quad  <= quad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg <= s0_x_reg;
            s1_z_reg <= signed'(residue);
        end
    end

    cordic_ctl_t            rot_ctl;
    logic signed [XY_W-1:0] rot_x;
    logic signed [XY_W-1:0] rot_y;

    stop_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (s1_ctl_reg),
        .in_x    (s1_x_reg),
        .in_z    (s1_z_reg),
        .out_ctl (rot_ctl),
        .out_x   (rot_x),
        .out_y   (rot_y)
    );

    // stage 2: quarter-turn rotation, magnitude biased by half a cm and cut to whole mm
    logic signed [XY_W-1:0] ox;
    logic signed [XY_W-1:0] oy;
    logic [XY_W-1:0]        abs_x;
    logic [XY_W-1:0]        abs_y;
    logic [XY_W:0]          bias_x;
    logic [XY_W:0]          bias_y;
    logic                   s2_valid_reg;
    logic                   s2_neg_x_reg;
    logic                   s2_neg_y_reg;
    logic [N_W-1:0]         s2_n_x_reg;
    logic [N_W-1:0]         s2_n_y_reg;

    always_comb
    begin
        unique case (rot_ctl.quad)
            QUAD_0:   begin ox = rot_x;  oy = rot_y;  end
            QUAD_90:  begin ox = -rot_y; oy = rot_x;  end
            QUAD_180: begin ox = -rot_x; oy = -rot_y; end
            QUAD_270: begin ox = rot_y;  oy = -rot_x; end
            default:  begin ox = rot_x;  oy = rot_y;  end
        endcase
    end

    assign abs_x  = ox[XY_W-1] ? XY_W'(-ox) : XY_W'(ox);
    assign abs_y  = oy[XY_W-1] ? XY_W'(-oy) : XY_W'(oy);
    assign bias_x = {1'b0, abs_x} + HALF_CM;
    assign bias_y = {1'b0, abs_y} + HALF_CM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= rot_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_neg_x_reg <= ox[XY_W-1];
            s2_neg_y_reg <= oy[XY_W-1];
            s2_n_x_reg   <= bias_x[XY_W:CM_FRAC];
            s2_n_y_reg   <= bias_y[XY_W:CM_FRAC];
        end
    end

    // stage 3: divide by ten through the reciprocal
    logic [N_W+RECIP_W-1:0] div_prod_x;
    logic [N_W+RECIP_W-1:0] div_prod_y;
    logic                   s3_valid_reg;
    logic                   s3_neg_x_reg;
    logic                   s3_neg_y_reg;
    logic [Q_W-1:0]         s3_q_x_reg;
    logic [Q_W-1:0]         s3_q_y_reg;

    assign div_prod_x = (N_W+RECIP_W)'(s2_n_x_reg) * (N_W+RECIP_W)'(RECIP_10);
    assign div_prod_y = (N_W+RECIP_W)'(s2_n_y_reg) * (N_W+RECIP_W)'(RECIP_10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_neg_x_reg <= s2_neg_x_reg;
            s3_neg_y_reg <= s2_neg_y_reg;
            s3_q_x_reg   <= div_prod_x[RECIP_SHIFT +: Q_W];
            s3_q_y_reg   <= div_prod_y[RECIP_SHIFT +: Q_W];
        end
    end

    // stage 4: sign, robot offset, saturation into the output register
    logic signed [SUM_W-1:0]   off_x;
    logic signed [SUM_W-1:0]   off_y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [COORD_W-1:0] sat_x;
    logic signed [COORD_W-1:0] sat_y;
    logic signed [COORD_W-1:0] point_x_reg;
    logic signed [COORD_W-1:0] point_y_reg;

    assign off_x = s3_neg_x_reg ? -signed'({2'b00, s3_q_x_reg}) : signed'({2'b00, s3_q_x_reg});
    assign off_y = s3_neg_y_reg ? -signed'({2'b00, s3_q_y_reg}) : signed'({2'b00, s3_q_y_reg});
    assign sum_x = signed'({{(SUM_W-COORD_W){robot_x_reg[COORD_W-1]}}, robot_x_reg}) + off_x;
    assign sum_y = signed'({{(SUM_W-COORD_W){robot_y_reg[COORD_W-1]}}, robot_y_reg}) + off_y;

    always_comb
    begin
        priority if (sum_x > SUM_W'(32767))
            sat_x = 16'sh7fff;
        else if (sum_x < -SUM_W'(32768))
            sat_x = -16'sh8000;
        else
            sat_x = sum_x[COORD_W-1:0];

        priority if (sum_y > SUM_W'(32767))
            sat_y = 16'sh7fff;
        else if (sum_y < -SUM_W'(32768))
            sat_y = -16'sh8000;
        else
            sat_y = sum_y[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            point_x_reg <= sat_x;
            point_y_reg <= sat_y;
        end
    end

    assign points.valid      = out_valid_reg;
    assign points.point_x_cm = point_x_reg;
    assign points.point_y_cm = point_y_reg;

endmodule

`default_nettype wire

// File: sv/stop_checker.sv
// port-level checks on the obstacle point converter, bound to the top level
`default_nettype none

module stop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_x,
    input logic [15:0] out_y
);

    // a held word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
        else $error("output word changed while stalled");

    // with nothing waiting at the output the pipeline never back-pressures
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // a blocked output freezes the whole pipeline
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output is blocked");

endmodule

bind scan_to_obstacle_points stop_checker u_stop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (samples.ready),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .out_x     (points.point_x_cm),
    .out_y     (points.point_y_cm)
);

`default_nettype wire
